// File: sv/awsu_pkg.sv
// shared types and constants for the anemometer window speed unit
// no dependencies
package awsu_pkg;

  localparam int COUNT_BITS = 16;
  localparam int KPH_W = COUNT_BITS + 16;

  localparam logic [15:0] WINDOW_MS_RST = 16'd1000;
  localparam logic [15:0] KPH_PER_COUNT_RST = 16'd614;
  localparam logic [15:0] BIAS_RST = 16'd0;

  // km/h limit, 80 in q8.8
  localparam logic [KPH_W-1:0] KPH_LIMIT_Q8 = KPH_W'(20480);
  // 65536 / 1.609, rounded
  localparam logic [15:0] MPH_PER_KPH_Q16 = 16'd40731;
  localparam logic [30:0] ROUND_HALF = 31'd32768;

  localparam logic [1:0] REG_WINDOW_MS = 2'd0;
  localparam logic [1:0] REG_KPH_PER_COUNT = 2'd1;
  localparam logic [1:0] REG_BIAS = 2'd2;

  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
  } event_t;

  typedef struct packed {
    logic [15:0] speed_q8;
    logic        speed_error;
  } result_t;

  typedef struct packed {
    logic [15:0]        window_ms;
    logic [15:0]        kph_per_count_q8;
    logic signed [15:0] bias_q8;
  } cfg_t;

endpackage

// File: sv/awsu_front.sv
// front end: window bookkeeping and pulse counting per event
// depends on awsu_pkg
module awsu_front (
  input  logic           clk,
  input  logic           rst,
  input  awsu_pkg::cfg_t cfg,
  input  logic           accept,
  input  awsu_pkg::event_t item,
  output logic           cq_push,
  output logic [awsu_pkg::COUNT_BITS-1:0] cq_data
);
  import awsu_pkg::*;

  logic [31:0]           window_start;
  logic [31:0]           window_start_next;
  logic [COUNT_BITS-1:0] pulse_count;
  logic [COUNT_BITS-1:0] pulse_count_next;
  logic [COUNT_BITS-1:0] last_count;
  logic [COUNT_BITS-1:0] last_count_next;
  logic [COUNT_BITS-1:0] closed_count;
  logic [31:0]           elapsed;
  logic [16:0]           two_windows;

  always_comb begin
    elapsed = item.now_ms - window_start;
    two_windows = {cfg.window_ms, 1'b0};
    window_start_next = window_start;
    closed_count = pulse_count;
    last_count_next = last_count;
    if (elapsed >= {16'd0, cfg.window_ms}) begin
      if (elapsed > {15'd0, two_windows}) begin
        // too long idle, restart at event time
        window_start_next = item.now_ms;
        closed_count = '0;
        last_count_next = '0;
      end else begin
        window_start_next = window_start + {16'd0, cfg.window_ms};
        last_count_next = pulse_count;
        closed_count = '0;
      end
    end
    pulse_count_next = closed_count;
    if (item.func == FUNC_PULSE && closed_count != {COUNT_BITS{1'b1}}) begin
      pulse_count_next = closed_count + COUNT_BITS'(1);
    end
  end

  assign cq_push = accept && item.func == FUNC_READ;
  assign cq_data = last_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      pulse_count <= '0;
      last_count <= '0;
    end else if (accept) begin
      window_start <= window_start_next;
      pulse_count <= pulse_count_next;
      last_count <= last_count_next;
    end
  end

endmodule

// File: sv/awsu_cnt_queue.sv
// two entry queue of latched counts between front and back
// depends on awsu_pkg
module awsu_cnt_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  logic [awsu_pkg::COUNT_BITS-1:0] wr_data,
  input  logic rd,
  output logic [awsu_pkg::COUNT_BITS-1:0] rd_data,
  output logic full,
  output logic empty
);
  import awsu_pkg::*;

  logic [COUNT_BITS-1:0] mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: sv/awsu_back.sv
// back end: count to km/h, range check, mph conversion, bias and clamp
// holds the result queue; depends on awsu_pkg
module awsu_back (
  input  logic           clk,
  input  logic           rst,
  input  awsu_pkg::cfg_t cfg,
  input  logic           cq_empty,
  input  logic [awsu_pkg::COUNT_BITS-1:0] cq_data,
  output logic           cq_pop,
  input  logic           pop,
  output logic           empty,
  output awsu_pkg::result_t result
);
  import awsu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]        state;
  logic [KPH_W-1:0]  kph;
  logic [30:0]       prod;
  logic              err;
  logic signed [16:0] neg_bias;
  logic              under;
  logic signed [17:0] diff;
  logic [15:0]       speed;

  result_t    oq [2];
  logic       oq_wr_ptr;
  logic       oq_rd_ptr;
  logic [1:0] oq_count;
  logic       oq_push;
  logic       oq_pop;

  always_comb begin
    neg_bias = 17'sd0 - {cfg.bias_q8[15], cfg.bias_q8};
    under = $signed({2'b00, kph}) < $signed({{(KPH_W-15){neg_bias[16]}}, neg_bias});
    diff = $signed({3'b000, prod[30:16]}) - $signed({{2{cfg.bias_q8[15]}}, cfg.bias_q8});
    if (diff <= 18'sd0) begin
      speed = '0;
    end else if (diff > 18'sd65535) begin
      speed = 16'hffff;
    end else begin
      speed = diff[15:0];
    end
  end

  assign cq_pop = state == ST_IDLE && !cq_empty && oq_count != 2'd2;
  assign oq_push = state == ST_FIN;
  assign oq_pop = pop && !empty;
  assign empty = oq_count == 2'd0;
  assign result = oq[oq_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cq_pop) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      kph <= KPH_W'(cq_data) * KPH_W'(cfg.kph_per_count_q8);
    end
    if (state == ST_MUL) begin
      err <= kph > KPH_LIMIT_Q8 || under;
      // kph is at most the limit whenever this product is used
      prod <= 31'(kph[14:0]) * 31'(MPH_PER_KPH_Q16) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr_ptr].speed_q8 <= err ? 16'd0 : speed;
      oq[oq_wr_ptr].speed_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= 1'b0;
      oq_rd_ptr <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wr_ptr <= ~oq_wr_ptr;
      end
      if (oq_pop) begin
        oq_rd_ptr <= ~oq_rd_ptr;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 2'd1;
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

endmodule

// File: sv/anemometer_window_speed_unit.sv
// anemometer window speed unit, top level: config registers, front, count queue, back
// depends on awsu_pkg, awsu_front, awsu_cnt_queue, awsu_back
// a read request passes through the count queue, then the back end states idle, multiply and finish before
// its result shows on the result ports; pulse requests: one per cycle while the count queue is not full;
//   reads are taken one at a time by the back end sequencer (multiply, convert, clamp), only when idle
// reset: synchronous; clears window state and queues, config returns to defaults
module anemometer_window_speed_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  awsu_pkg::event_t  event_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output awsu_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import awsu_pkg::*;

  // configuration; the user must change it only while the unit is idle, the block does not enforce this
  cfg_t cfg;

  logic                  accept;
  logic                  cq_push;
  logic [COUNT_BITS-1:0] cq_wr_data;
  logic [COUNT_BITS-1:0] cq_rd_data;
  logic                  cq_pop;
  logic                  cq_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms <= WINDOW_MS_RST;
      cfg.kph_per_count_q8 <= KPH_PER_COUNT_RST;
      cfg.bias_q8 <= BIAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_MS: begin
          cfg.window_ms <= cfg_data;
        end
        REG_KPH_PER_COUNT: begin
          cfg.kph_per_count_q8 <= cfg_data;
        end
        REG_BIAS: begin
          cfg.bias_q8 <= cfg_data;
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // every request waits for a free queue slot, so ordering stays simple
  assign accept = push && !full;

  // front: closes the window and counts pulses in the accept cycle,
  // reads leave a snapshot of the latched count in the queue
  awsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .item    (event_item),
    .cq_push (cq_push),
    .cq_data (cq_wr_data)
  );

  // short queue so the front keeps taking pulses while the back converts
  awsu_cnt_queue u_cnt_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cq_push),
    .wr_data (cq_wr_data),
    .rd      (cq_pop),
    .rd_data (cq_rd_data),
    .full    (full),
    .empty   (cq_empty)
  );

  // back: speed arithmetic and result queue
  awsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cq_empty (cq_empty),
    .cq_data  (cq_rd_data),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// File: tb/sv/anemometer_window_speed_unit_test.sv
// self-checking testbench for anemometer_window_speed_unit: directed window, limit and
// wrap cases, a back-to-back pulse run, then random pulse/read traffic with bursty requests
// depends on awsu_pkg and the anemometer_window_speed_unit rtl
`timescale 1ns / 1ps

module anemometer_window_speed_unit_test;
  import awsu_pkg::*;

  // 80 km/h in q8.8 and 65536/1.609 rounded
  localparam longint KPH_CEILING = 80 * 256;
  localparam longint MPH_FACTOR = 40731;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int RUN_PULSES = 256;

  logic clk;
  logic rst;
  logic push;
  event_t event_item;
  logic full;
  logic pop;
  logic empty;
  result_t result;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  anemometer_window_speed_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .event_item (event_item),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state, mirrors the block after reset
  logic [31:0] win_start_m = '0;
  logic [COUNT_BITS-1:0] run_count_m = '0;
  logic [COUNT_BITS-1:0] last_count_m = '0;
  logic [15:0] window_len_m = 16'd1000;
  logic [15:0] kph_scale_m = 16'd614;
  logic signed [15:0] bias_m = 16'sd0;

  // speeds still owed by the block, oldest first
  result_t pending_speeds[$];

  int fail_count = 0;
  int pulses_sent = 0;
  int reads_sent = 0;
  int reads_checked = 0;
  int flagged_reads = 0;
  int config_writes = 0;
  int random_items = 0;

  // sender burst state
  bit bursty = 1'b1;
  int burst_left = 0;

  result_t got_r;
  result_t exp_r;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d speeds still pending", pending_speeds.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 30) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // close the counting window for an event at time now
  function automatic void close_window_model(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [32:0] two_periods;
    elapsed = now - win_start_m;
    two_periods = 33'(window_len_m) << 1;
    if (elapsed >= 32'(window_len_m)) begin
      if (33'(elapsed) > two_periods) begin
        // stale by more than two periods: start over at this event
        win_start_m = now;
        run_count_m = '0;
        last_count_m = '0;
      end else begin
        win_start_m = win_start_m + 32'(window_len_m);
        last_count_m = run_count_m;
        run_count_m = '0;
      end
    end
  endfunction

  // latched count -> kph -> mph minus bias, clamped, or the error flag
  function automatic result_t convert_speed_model();
    longint kph;
    longint mph;
    longint spd;
    longint bias_l;
    result_t r;
    kph = longint'(last_count_m) * longint'(kph_scale_m);
    bias_l = longint'(bias_m);
    r = '0;
    if (kph > KPH_CEILING || kph < -bias_l) begin
      r.speed_error = 1'b1;
    end else begin
      mph = (kph * MPH_FACTOR + 32768) >>> 16;
      spd = mph - bias_l;
      if (spd <= 0) begin
        spd = 0;
      end else if (spd > 65535) begin
        spd = 65535;
      end
      r.speed_q8 = 16'(spd);
    end
    return r;
  endfunction

  function automatic void predict_wind_speed(input event_t ev);
    result_t r;
    close_window_model(ev.now_ms);
    if (ev.func == FUNC_PULSE) begin
      if (run_count_m != '1) begin
        run_count_m = run_count_m + 1'b1;
      end
      pulses_sent++;
    end else begin
      r = convert_speed_model();
      pending_speeds.push_back(r);
      reads_sent++;
      if (r.speed_error) begin
        flagged_reads++;
      end
    end
  endfunction

  // one request; called and returns just after a falling edge
  task automatic send_event(input logic f, input logic [31:0] now);
    if (bursty && burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    push = 1'b1;
    event_item = {f, now};
    do @(posedge clk); while (full);
    predict_wind_speed(event_item);
    @(negedge clk);
  endtask

  // stop sending, let every owed speed come out, then let pulses drain too
  task automatic settle();
    push = 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_MS: window_len_m = val;
      REG_KPH_PER_COUNT: kph_scale_m = val;
      REG_BIAS: bias_m = val;
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, checker on every accepted result
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    int mode;
    int span;
    pop = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: pop = 1'b1;                           // no stalls at all
          1: pop = $urandom_range(0, 1);           // coin flip
          2: pop = ($urandom_range(0, 7) == 0);    // long stalls
          default: pop = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got_r = result;
      if (pending_speeds.size() == 0) begin
        report_mismatch($sformatf("speed result %h/%b with no read pending",
                                  got_r.speed_q8, got_r.speed_error));
      end else begin
        exp_r = pending_speeds.pop_front();
        reads_checked++;
        if (got_r.speed_q8 !== exp_r.speed_q8) begin
          report_mismatch($sformatf("read %0d speed_q8 %h, want %h",
                                    reads_checked, got_r.speed_q8, exp_r.speed_q8));
        end
        if (got_r.speed_error !== exp_r.speed_error) begin
          report_mismatch($sformatf("read %0d speed_error %b, want %b",
                                    reads_checked, got_r.speed_error, exp_r.speed_error));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // nothing latched yet: zero speed, no error
  task automatic test_reset_defaults();
    send_event(FUNC_READ, 32'd0);
  endtask

  // pulses in the first window, read exactly one period later and again late in it
  task automatic test_window_latch();
    send_event(FUNC_PULSE, 32'd10);
    send_event(FUNC_PULSE, 32'd20);
    send_event(FUNC_PULSE, 32'd30);
    send_event(FUNC_READ, 32'd1000);
    send_event(FUNC_READ, 32'd1999);
  endtask

  // exactly two periods still advances; just past two periods clears
  task automatic test_two_period_edge();
    logic [31:0] t;
    send_event(FUNC_PULSE, win_start_m + 32'd500);
    t = win_start_m + 32'd2000;
    send_event(FUNC_READ, t);
    t = win_start_m + 32'd2001;
    send_event(FUNC_READ, t);
  endtask

  // km/h just at and just past 80 with a single latched pulse
  task automatic test_overspeed();
    logic [31:0] t;
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'hFFFF);
    t = win_start_m;
    send_event(FUNC_PULSE, t);
    t = t + 32'd1000;
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'd20480);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'd20481);
    send_event(FUNC_READ, t);
  endtask

  // bias extremes: negative bias as lower limit, positive bias clamping at zero
  task automatic test_bias_limits();
    logic [31:0] t;
    t = win_start_m;
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'd20480);
    write_reg(REG_BIAS, 16'h8000);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_BIAS, 16'h7FFF);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'd0);
    write_reg(REG_BIAS, 16'hFFFF);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_KPH_PER_COUNT, 16'd200);
    write_reg(REG_BIAS, -16'sd256);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_BIAS, -16'sd100);
    send_event(FUNC_READ, t);
    settle();
    write_reg(REG_BIAS, 16'd0);
    write_reg(REG_KPH_PER_COUNT, 16'd614);
  endtask

  // stamps across the 2^32 wrap, and a stamp earlier than the window start
  task automatic test_time_wrap();
    send_event(FUNC_READ, 32'hFFFF_FFFF);
    send_event(FUNC_PULSE, 32'hFFFF_FFFF);
    send_event(FUNC_READ, 32'hFFFF_FFFF + 32'd1000);
    send_event(FUNC_READ, 32'd998);
  endtask

  // zero-length window: same stamp latches, any later stamp restarts
  task automatic test_zero_window();
    settle();
    write_reg(REG_WINDOW_MS, 16'd0);
    send_event(FUNC_READ, 32'd5000);
    send_event(FUNC_PULSE, 32'd5000);
    send_event(FUNC_READ, 32'd5000);
    send_event(FUNC_READ, 32'd5001);
    settle();
    write_reg(REG_WINDOW_MS, 16'd1000);
  endtask

  // a back-to-back pulse run at one stamp, then a read of the latched count
  task automatic test_pulse_run();
    logic [31:0] t;
    settle();
    write_reg(REG_WINDOW_MS, 16'hFFFF);
    write_reg(REG_KPH_PER_COUNT, 16'd1);
    bursty = 1'b0;
    t = 32'h1234_5678;
    repeat (RUN_PULSES) send_event(FUNC_PULSE, t);
    t = win_start_m + 32'(window_len_m);
    send_event(FUNC_READ, t);
    bursty = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // random traffic in phases, each phase with its own register setting
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic();
    logic [31:0] t;
    logic [15:0] val;
    logic f;
    int phase_len;
    int roll;
    bit held_once;
    t = win_start_m;
    held_once = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: val = 16'd1;
        1: val = 16'hFFFF;
        2: val = 16'($urandom_range(1, 65535));
        default: val = 16'($urandom_range(2, 64));
      endcase
      write_reg(REG_WINDOW_MS, val);
      case ($urandom_range(0, 9))
        0: val = 16'd0;
        1: val = 16'hFFFF;
        2: val = 16'($urandom);
        default: val = 16'($urandom_range(0, 4000));
      endcase
      write_reg(REG_KPH_PER_COUNT, val);
      case ($urandom_range(0, 9))
        0: val = 16'h8000;
        1: val = 16'h7FFF;
        2: val = 16'($urandom);
        default: val = 16'($urandom_range(0, 1000)) - 16'd500;
      endcase
      write_reg(REG_BIAS, val);

      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          t = $urandom;                                 // arbitrary stamp, often a restart
        end else if (roll < 8) begin
          t = t + $urandom_range(0, 3 * window_len_m + 1);
        end else begin
          t = t + $urandom_range(0, window_len_m / 4 + 1);
        end
        f = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_PULSE;
        send_event(f, t);
        random_items++;
        // hold the sender once mid-run until every owed speed is back
        if (!held_once && random_items >= RANDOM_ITEMS / 2) begin
          held_once = 1'b1;
          push = 1'b0;
          while (pending_speeds.size() != 0) @(negedge clk);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    push = 1'b0;
    event_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WINDOW_MS;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_window_latch();
    test_two_period_edge();
    test_overspeed();
    test_bias_limits();
    test_time_wrap();
    test_zero_window();
    test_pulse_run();
    test_random_traffic();

    // drain: every read answered, then a settle wait for anything trailing
    settle();

    $display("sent %0d pulse and %0d read requests, %0d register writes",
             pulses_sent, reads_sent, config_writes);
    $display("checked %0d speed results, %0d of them flagged out of range",
             reads_checked, flagged_reads);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
